FILE: rtl/hs_pkg.sv
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types and constants for the heap sorter: word layouts of the
// input and result channels.
// ----------------------------------------------------------------------------
package hs_pkg;

    // width of one element
    localparam int DATA_W = 32;

    // input word: one element, plus the flag that closes the set
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_word;

    // result word: next element in ascending order
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_run;
        logic                     overflow;
    } t_out_word;

endpackage

FILE: rtl/heap_sorter.sv
// ----------------------------------------------------------------------------
// heap_sorter
// Heap sort of a set of signed words kept in one RAM. Loads one word per
// cycle, builds a max-heap by sift-down, extracts the root into the tail
// and streams the set out in ascending order.
// ----------------------------------------------------------------------------
// Load: one word per cycle, ready held high while collecting a set.
// Sort: each sift level steps through left read, right read, child select
//   and move; the single RAM read port paces every step.
// Output: each result word is read, captured and held until taken; input is
//   blocked until the last word of the run is taken.
// Reset clears the control state and counters only; the RAM is not cleared.
// ----------------------------------------------------------------------------
module heap_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hs_pkg::t_in_word  i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output hs_pkg::t_out_word o_data
);

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int CIW = AW + 2;
    localparam int DW  = hs_pkg::DATA_W;

    // sequencer states
    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_BUILD     = 4'd1;
    localparam logic [3:0] ST_SIFT_RD   = 4'd2;
    localparam logic [3:0] ST_SIFT_HOLD = 4'd3;
    localparam logic [3:0] ST_SIFT_L    = 4'd4;
    localparam logic [3:0] ST_SIFT_R    = 4'd5;
    localparam logic [3:0] ST_SIFT_CMP  = 4'd6;
    localparam logic [3:0] ST_SIFT_DEC  = 4'd7;
    localparam logic [3:0] ST_EX_NEXT   = 4'd8;
    localparam logic [3:0] ST_EX_RD0    = 4'd9;
    localparam logic [3:0] ST_EX_RDK    = 4'd10;
    localparam logic [3:0] ST_EX_WK     = 4'd11;
    localparam logic [3:0] ST_OUT_RD    = 4'd12;
    localparam logic [3:0] ST_OUT_CAP   = 4'd13;
    localparam logic [3:0] ST_OUT_HOLD  = 4'd14;

    // control registers
    logic [3:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic        r_dropped, n_dropped;
    // working registers
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_size, n_size;
    logic [CW-1:0] r_bk, n_bk;
    logic [CW-1:0] r_ek, n_ek;
    logic [AW-1:0] r_node, n_node;
    logic [AW-1:0] r_cidx, n_cidx;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_phase_ex, n_phase_ex;
    logic signed [DW-1:0] r_held, n_held;
    logic signed [DW-1:0] r_child, n_child;
    logic signed [DW-1:0] r_top, n_top;
    hs_pkg::t_out_word    r_out, n_out;

    // RAM port signals
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;

    logic [CIW-1:0] w_left;
    logic [CIW-1:0] w_right;
    logic [CW-1:0]  w_cnt_inc;

    hs_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // children of the current node
    assign w_left  = CIW'({r_node, 1'b1});
    assign w_right = CIW'({r_node, 1'b0}) + CIW'(2);

    assign o_ready = (r_state == ST_LOAD);
    assign o_valid = (r_state == ST_OUT_HOLD);
    assign o_data  = r_out;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_n        = r_n;
        n_size     = r_size;
        n_bk       = r_bk;
        n_ek       = r_ek;
        n_node     = r_node;
        n_cidx     = r_cidx;
        n_idx      = r_idx;
        n_phase_ex = r_phase_ex;
        n_held     = r_held;
        n_child    = r_child;
        n_top      = r_top;
        n_out      = r_out;
        w_we       = 1'b0;
        w_waddr    = r_node;
        w_wdata    = r_held;
        w_raddr    = r_node;
        w_cnt_inc  = r_count;

        case (r_state)
            // collect words in arrival order
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        w_we      = 1'b1;
                        w_waddr   = AW'(r_count);
                        w_wdata   = i_data.value;
                        w_cnt_inc = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    n_count = w_cnt_inc;
                    if (i_data.last) begin
                        n_n        = w_cnt_inc;
                        n_bk       = w_cnt_inc >> 1;
                        n_phase_ex = 1'b0;
                        n_state    = ST_BUILD;
                    end
                end
            end
            // heap build: sift each parent from the middle down to the root
            ST_BUILD: begin
                if (r_bk == '0) begin
                    n_phase_ex = 1'b1;
                    n_ek       = r_n - CW'(1);
                    n_state    = ST_EX_NEXT;
                end else begin
                    n_node  = AW'(r_bk - CW'(1));
                    n_bk    = r_bk - CW'(1);
                    n_size  = r_n;
                    n_state = ST_SIFT_RD;
                end
            end
            ST_SIFT_RD: begin
                w_raddr = r_node;
                n_state = ST_SIFT_HOLD;
            end
            ST_SIFT_HOLD: begin
                n_held  = w_rdata;
                n_state = ST_SIFT_L;
            end
            // sift-down with a hole: the held word moves only at the end
            ST_SIFT_L: begin
                if (w_left >= CIW'(r_size)) begin
                    w_we    = 1'b1;
                    w_waddr = r_node;
                    w_wdata = r_held;
                    if (r_phase_ex) begin
                        n_ek    = r_ek - CW'(1);
                        n_state = ST_EX_NEXT;
                    end else begin
                        n_state = ST_BUILD;
                    end
                end else begin
                    w_raddr = w_left[AW-1:0];
                    n_state = ST_SIFT_R;
                end
            end
            ST_SIFT_R: begin
                n_child = w_rdata;
                n_cidx  = w_left[AW-1:0];
                if (w_right < CIW'(r_size)) begin
                    w_raddr = w_right[AW-1:0];
                    n_state = ST_SIFT_CMP;
                end else begin
                    n_state = ST_SIFT_DEC;
                end
            end
            // right child wins only when strictly greater
            ST_SIFT_CMP: begin
                if ($signed(w_rdata) > r_child) begin
                    n_child = w_rdata;
                    n_cidx  = w_right[AW-1:0];
                end
                n_state = ST_SIFT_DEC;
            end
            ST_SIFT_DEC: begin
                w_we    = 1'b1;
                w_waddr = r_node;
                if (r_child > r_held) begin
                    w_wdata = r_child;
                    n_node  = r_cidx;
                    n_state = ST_SIFT_L;
                end else begin
                    w_wdata = r_held;
                    if (r_phase_ex) begin
                        n_ek    = r_ek - CW'(1);
                        n_state = ST_EX_NEXT;
                    end else begin
                        n_state = ST_BUILD;
                    end
                end
            end
            // extraction: root goes to the tail, tail word sifts from the root
            ST_EX_NEXT: begin
                if (r_ek == '0) begin
                    n_idx   = '0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_state = ST_EX_RD0;
                end
            end
            ST_EX_RD0: begin
                w_raddr = '0;
                n_state = ST_EX_RDK;
            end
            ST_EX_RDK: begin
                n_top   = w_rdata;
                w_raddr = AW'(r_ek);
                n_state = ST_EX_WK;
            end
            ST_EX_WK: begin
                n_held  = w_rdata;
                w_we    = 1'b1;
                w_waddr = AW'(r_ek);
                w_wdata = r_top;
                n_size  = r_ek;
                n_node  = '0;
                n_state = ST_SIFT_L;
            end
            // stream out in ascending order
            ST_OUT_RD: begin
                w_raddr = r_idx;
                n_state = ST_OUT_CAP;
            end
            ST_OUT_CAP: begin
                n_out.sorted_value = w_rdata;
                n_out.end_of_run   = (CW'(r_idx) + CW'(1) == r_n);
                n_out.overflow     = r_dropped;
                n_state            = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (i_ready) begin
                    if (r_out.end_of_run) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_size     <= n_size;
        r_bk       <= n_bk;
        r_ek       <= n_ek;
        r_node     <= n_node;
        r_cidx     <= n_cidx;
        r_idx      <= n_idx;
        r_phase_ex <= n_phase_ex;
        r_held     <= n_held;
        r_child    <= n_child;
        r_top      <= n_top;
        r_out      <= n_out;
    end

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("fill count beyond store depth");

    // a finished run leaves the block empty for the next set
    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.end_of_run) |=> (r_count == '0 && !r_dropped))
        else $error("run end did not clear count and drop flag");

    // input is never taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input and output active together");

    // sift node always lies inside the live heap
    a_node_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIFT_L) |-> (CW'(r_node) < r_size))
        else $error("sift node outside heap");

    // the last result index matches the run length
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.end_of_run) |-> (CW'(r_idx) + CW'(1) == r_n))
        else $error("end of run at wrong index");

endmodule

FILE: rtl/hs_ram.sv
// ----------------------------------------------------------------------------
// hs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A same-address read and write in one cycle returns the old data.
// ----------------------------------------------------------------------------
module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
